### sv/tcsr_pkg.sv
// tcsr_pkg: shared constants, command codes and controller/datapath structs
// for the textured column and span rasteriser; no dependencies
package tcsr_pkg;

   localparam int SCREEN_W     = 320;
   localparam int SCREEN_H     = 200;
   localparam int COLUMN_SLOTS = 256;
   localparam int COLUMN_BYTES = 128;
   localparam int FLAT_BYTES   = 4096;
   localparam int LIGHT_LEVELS = 32;

   localparam int FRAME_PIXELS = SCREEN_W * SCREEN_H;
   localparam int FB_AW        = $clog2(FRAME_PIXELS);
   localparam int SLOT_W       = (COLUMN_SLOTS > 1) ? $clog2(COLUMN_SLOTS) : 1;
   localparam int CB_W         = $clog2(COLUMN_BYTES);
   localparam int CS_AW        = SLOT_W + CB_W;
   localparam int FLAT_AW      = $clog2(FLAT_BYTES);
   localparam int LVL_W        = 5;
   localparam int LIGHT_AW     = LVL_W + 8;

   typedef enum logic [2:0] {
      CMD_LIGHT_WRITE = 3'd0,
      CMD_COLUMN_FILL = 3'd1,
      CMD_FLAT_FILL   = 3'd2,
      CMD_COLUMN      = 3'd3,
      CMD_SPAN        = 3'd4,
      CMD_CLEAR       = 3'd5,
      CMD_READ        = 3'd6,
      CMD_INVALIDATE  = 3'd7
   } opcode_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_COL_MISS  = 2'd1,
      ST_FLAT_MISS = 2'd2,
      ST_SKIP      = 2'd3
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // latch the accepted word
      logic exec;      // non-walking commands and draw pre-checks
      logic pix_step;  // issue one pixel
      logic clr_step;  // clear one frame pixel
      logic clr_start;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_draw;
      logic is_clear;
      logic is_read;
      logic draw_go;   // draw passed all checks
      logic pix_last;
      logic clr_last;
      logic pipe_busy; // pixel pipeline still holds writes
   } dp_stat_type;

endpackage

### sv/tcsr_ctrl.sv
// tcsr_ctrl: command sequencer for the rasteriser
// depends on tcsr_pkg
module tcsr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   output logic                    out_valid,
   input  logic                    out_ready,
   output tcsr_pkg::dp_cmd_type    cmd,
   input  tcsr_pkg::dp_stat_type   stat
);

   typedef enum logic [6:0] {
      S_INIT  = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_EXEC  = 7'b0000100,
      S_DRAW  = 7'b0001000,
      S_CLEAR = 7'b0010000,
      S_DRAIN = 7'b0100000,
      S_RESP  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      in_ready  = 1'b0;
      out_valid = 1'b0;
      unique case (state_ff)
         // sweep after reset, no response word
         S_INIT: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            priority if (stat.is_clear) begin
               cmd.clr_start = 1'b1;
               state_in      = S_CLEAR;
            end else if (stat.is_draw && stat.draw_go) begin
               state_in = S_DRAW;
            end else if (stat.is_read) begin
               state_in = S_DRAIN;
            end else begin
               state_in = S_RESP;
            end
         end
         S_DRAW: begin
            cmd.pix_step = 1'b1;
            if (stat.pix_last) begin
               state_in = S_DRAIN;
            end
         end
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = S_RESP;
            end
         end
         S_DRAIN: begin
            if (!stat.pipe_busy) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            out_valid = 1'b1;
            if (out_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

### sv/tcsr_datapath.sv
// tcsr_datapath: texture, light and frame stores with the pixel pipeline
// depends on tcsr_pkg; driven by tcsr_ctrl
module tcsr_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [2:0]              command,
   input  logic [4:0]              light_level,
   input  logic [15:0]             load_index,
   input  logic [7:0]              load_value,
   input  logic [15:0]             x_start,
   input  logic [15:0]             x_end,
   input  logic [15:0]             y_start,
   input  logic [15:0]             y_end,
   input  logic [31:0]             tex_coord,
   input  logic [31:0]             tex_step,
   input  logic [31:0]             texture_offset,
   input  tcsr_pkg::dp_cmd_type    cmd,
   output tcsr_pkg::dp_stat_type   stat,
   output logic [1:0]              status,
   output logic [7:0]              read_value
);

   // latched command word
   tcsr_pkg::opcode_type cmd_ff;
   logic [4:0]  lvl_ff;
   logic [15:0] lidx_ff;
   logic [7:0]  lval_ff;
   logic [15:0] xs_ff, xe_ff, ys_ff, ye_ff;
   logic [31:0] coord_ff, step_ff, offs_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff   <= tcsr_pkg::opcode_type'(command);
         lvl_ff   <= light_level;
         lidx_ff  <= load_index;
         lval_ff  <= load_value;
         xs_ff    <= x_start;
         xe_ff    <= x_end;
         ys_ff    <= y_start;
         ye_ff    <= y_end;
         coord_ff <= tex_coord;
         step_ff  <= tex_step;
         offs_ff  <= texture_offset;
      end else if (cmd.pix_step) begin
         coord_ff <= coord_ff + step_ff;
      end
   end

   // memories
   logic [7:0]  frame_mem  [tcsr_pkg::FRAME_PIXELS];
   logic [7:0]  light_mem  [1 << tcsr_pkg::LIGHT_AW];
   logic [7:0]  column_mem [tcsr_pkg::COLUMN_SLOTS * tcsr_pkg::COLUMN_BYTES];
   logic [7:0]  flat_mem   [tcsr_pkg::FLAT_BYTES];
   logic [31:0] tag_mem    [tcsr_pkg::COLUMN_SLOTS];
   logic [tcsr_pkg::COLUMN_SLOTS-1:0] col_valid_ff;
   logic [31:0] flat_tag_ff;
   logic        flat_valid_ff;

   // decode
   logic [tcsr_pkg::SLOT_W-1:0] slot;
   logic [tcsr_pkg::CB_W-1:0]   cbyte;
   logic [tcsr_pkg::FLAT_AW-1:0] fbyte;
   logic is_col, is_span;
   logic [15:0] ylim_s, ylim_e, xlim_s, xlim_e;
   logic col_skip, span_skip;
   logic [4:0] lvl_eff;
   logic       lvl_ok;

   assign slot    = tcsr_pkg::SLOT_W'(offs_ff[31:7] % tcsr_pkg::COLUMN_SLOTS);
   assign cbyte   = lidx_ff[tcsr_pkg::CB_W-1:0];
   assign fbyte   = lidx_ff[tcsr_pkg::FLAT_AW-1:0];
   assign is_col  = (cmd_ff == tcsr_pkg::CMD_COLUMN);
   assign is_span = (cmd_ff == tcsr_pkg::CMD_SPAN);
   assign ylim_s  = (ys_ff < 16'(tcsr_pkg::SCREEN_H)) ? ys_ff : 16'(tcsr_pkg::SCREEN_H - 1);
   assign ylim_e  = (ye_ff < 16'(tcsr_pkg::SCREEN_H)) ? ye_ff : 16'(tcsr_pkg::SCREEN_H - 1);
   assign xlim_s  = (xs_ff < 16'(tcsr_pkg::SCREEN_W)) ? xs_ff : 16'(tcsr_pkg::SCREEN_W - 1);
   assign xlim_e  = (xe_ff < 16'(tcsr_pkg::SCREEN_W)) ? xe_ff : 16'(tcsr_pkg::SCREEN_W - 1);
   assign col_skip  = (xs_ff >= 16'(tcsr_pkg::SCREEN_W)) || (ylim_s > ylim_e);
   assign span_skip = (ys_ff >= 16'(tcsr_pkg::SCREEN_H)) || (xlim_s > xlim_e);
   // compare one bit wider so a full 32-level table is not seen as zero
   assign lvl_ok  = ({1'b0, lvl_ff} < 6'(tcsr_pkg::LIGHT_LEVELS));
   assign lvl_eff = lvl_ok ? lvl_ff : 5'(tcsr_pkg::LIGHT_LEVELS - 1);

   // tag read registered when the word is accepted, ready for the checks
   logic [31:0] tag_q_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         tag_q_ff <= tag_mem[tcsr_pkg::SLOT_W'(texture_offset[31:7] % tcsr_pkg::COLUMN_SLOTS)];
      end
   end

   logic col_hit, flat_hit;
   assign col_hit  = col_valid_ff[slot] && (tag_q_ff == offs_ff);
   assign flat_hit = flat_valid_ff && (flat_tag_ff == offs_ff);

   // walk counters
   logic [15:0] pos_ff, last_ff;
   logic [tcsr_pkg::FB_AW-1:0] fb_ptr_ff, clr_ptr_ff;
   logic [tcsr_pkg::FB_AW-1:0] pix_stride;
   assign pix_stride = is_col ? tcsr_pkg::FB_AW'(tcsr_pkg::SCREEN_W) : tcsr_pkg::FB_AW'(1);

   logic [31:0] row_base;
   assign row_base = 32'(ys_ff) * 32'(tcsr_pkg::SCREEN_W);

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         if (is_col) begin
            pos_ff    <= ylim_s;
            last_ff   <= ylim_e;
            fb_ptr_ff <= tcsr_pkg::FB_AW'(32'(ylim_s) * 32'(tcsr_pkg::SCREEN_W) + 32'(xs_ff));
         end else begin
            pos_ff    <= xlim_s;
            last_ff   <= xlim_e;
            fb_ptr_ff <= tcsr_pkg::FB_AW'(row_base + 32'(xlim_s));
         end
      end else if (cmd.pix_step) begin
         pos_ff    <= pos_ff + 16'd1;
         fb_ptr_ff <= fb_ptr_ff + pix_stride;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clr_start) begin
         clr_ptr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_ptr_ff <= clr_ptr_ff + tcsr_pkg::FB_AW'(1);
      end
   end

   // stage 1: texel fetch
   logic [tcsr_pkg::CS_AW-1:0]   cs_addr;
   logic [tcsr_pkg::FLAT_AW-1:0] spot;
   assign cs_addr = {slot, coord_ff[16 +: tcsr_pkg::CB_W]};
   assign spot    = tcsr_pkg::FLAT_AW'((((coord_ff >> 4) & 32'h0fc0) | (coord_ff >> 26)) & 32'd4095);

   logic       p1_v_ff, p2_v_ff;
   logic [7:0] texel_col_ff, texel_flat_ff, light_q_ff;
   logic       p1_col_ff;
   logic [4:0] p1_lvl_ff;
   logic [tcsr_pkg::FB_AW-1:0] p1_ptr_ff, p2_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
      end else begin
         p1_v_ff <= cmd.pix_step;
         p2_v_ff <= p1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      texel_col_ff  <= column_mem[cs_addr];
      texel_flat_ff <= flat_mem[spot];
      p1_col_ff     <= is_col;
      p1_lvl_ff     <= lvl_eff;
      p1_ptr_ff     <= fb_ptr_ff;
      // stage 2: light lookup
      light_q_ff    <= light_mem[{p1_lvl_ff, p1_col_ff ? texel_col_ff : texel_flat_ff}];
      p2_ptr_ff     <= p1_ptr_ff;
   end

   // store writes
   always_ff @(posedge clock) begin
      if (cmd.exec && cmd_ff == tcsr_pkg::CMD_LIGHT_WRITE && lvl_ok) begin
         light_mem[{lvl_ff, lidx_ff[7:0]}] <= lval_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && cmd_ff == tcsr_pkg::CMD_COLUMN_FILL) begin
         column_mem[{slot, cbyte}] <= lval_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && cmd_ff == tcsr_pkg::CMD_COLUMN_FILL &&
          cbyte == tcsr_pkg::CB_W'(tcsr_pkg::COLUMN_BYTES - 1)) begin
         tag_mem[slot] <= offs_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && cmd_ff == tcsr_pkg::CMD_FLAT_FILL) begin
         flat_mem[fbyte] <= lval_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && cmd_ff == tcsr_pkg::CMD_FLAT_FILL &&
          fbyte == tcsr_pkg::FLAT_AW'(tcsr_pkg::FLAT_BYTES - 1)) begin
         flat_tag_ff <= offs_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_valid_ff  <= '0;
         flat_valid_ff <= 1'b0;
      end else if (cmd.exec) begin
         unique case (cmd_ff)
            tcsr_pkg::CMD_COLUMN_FILL: begin
               col_valid_ff[slot] <= (cbyte == tcsr_pkg::CB_W'(tcsr_pkg::COLUMN_BYTES - 1));
            end
            tcsr_pkg::CMD_FLAT_FILL: begin
               flat_valid_ff <= (fbyte == tcsr_pkg::FLAT_AW'(tcsr_pkg::FLAT_BYTES - 1));
            end
            tcsr_pkg::CMD_CLEAR: flat_valid_ff <= 1'b0;
            tcsr_pkg::CMD_INVALIDATE: begin
               col_valid_ff  <= '0;
               flat_valid_ff <= 1'b0;
            end
            default: ;
         endcase
      end
   end

   // frame store: one write port shared by clear sweep and pixel pipe, one read port
   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         frame_mem[clr_ptr_ff] <= 8'd0;
      end else if (p2_v_ff) begin
         frame_mem[p2_ptr_ff] <= light_q_ff;
      end
   end

   logic [7:0] fb_q_ff;
   always_ff @(posedge clock) begin
      fb_q_ff <= frame_mem[lidx_ff[tcsr_pkg::FB_AW-1:0]];
   end

   // result
   logic [1:0] status_ff;
   logic       rd_ok_ff;
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff <= tcsr_pkg::ST_DONE;
         rd_ok_ff  <= 1'b0;
         unique case (cmd_ff)
            tcsr_pkg::CMD_COLUMN: begin
               if (col_skip) status_ff <= tcsr_pkg::ST_SKIP;
               else if (!col_hit) status_ff <= tcsr_pkg::ST_COL_MISS;
            end
            tcsr_pkg::CMD_SPAN: begin
               if (span_skip) status_ff <= tcsr_pkg::ST_SKIP;
               else if (!flat_hit) status_ff <= tcsr_pkg::ST_FLAT_MISS;
            end
            tcsr_pkg::CMD_READ: begin
               if (lidx_ff >= 16'(tcsr_pkg::FRAME_PIXELS)) status_ff <= tcsr_pkg::ST_SKIP;
               else rd_ok_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   assign status     = status_ff;
   assign read_value = rd_ok_ff ? fb_q_ff : 8'd0;

   assign stat.is_draw   = is_col || is_span;
   assign stat.is_clear  = (cmd_ff == tcsr_pkg::CMD_CLEAR);
   assign stat.is_read   = (cmd_ff == tcsr_pkg::CMD_READ);
   assign stat.draw_go   = is_col ? (!col_skip && col_hit) : (!span_skip && flat_hit);
   assign stat.pix_last  = (pos_ff == last_ff);
   assign stat.clr_last  = (clr_ptr_ff == tcsr_pkg::FB_AW'(tcsr_pkg::FRAME_PIXELS - 1));
   assign stat.pipe_busy = p1_v_ff || p2_v_ff;

endmodule

### sv/textured_column_span_rasterizer_core.sv
// textured_column_span_rasterizer_core: top level, sequencer plus datapath
// depends on tcsr_pkg, tcsr_ctrl, tcsr_datapath
// request to response: fills, light writes, invalidate, skips and misses go straight to
// the response; reads and draws drain the pixel pipe first, a draw at one pixel a cycle;
// clear sweeps one pixel a cycle; one word in flight, next accepted after the response;
// reset (synchronous, active high) sweeps 64000 pixels to zero before req_tready rises
module textured_column_span_rasterizer_core (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // light_level[4:0] load_index[20:5] load_value[28:21] x_start[44:29] x_end[60:45]
   // y_start[76:61] y_end[92:77] tex_coord[124:93] tex_step[156:125]
   // texture_offset[188:157], zero fill above
   input  logic [191:0]  req_tdata,
   // command[2:0]
   input  logic [2:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // status[1:0] read_value[9:2], zero fill above
   output logic [15:0]   rsp_tdata
);

   tcsr_pkg::dp_cmd_type  cmd;
   tcsr_pkg::dp_stat_type stat;
   logic [1:0] status;
   logic [7:0] read_value;

   tcsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .cmd       (cmd),
      .stat      (stat)
   );

   tcsr_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .command        (req_tuser),
      .light_level    (req_tdata[4:0]),
      .load_index     (req_tdata[20:5]),
      .load_value     (req_tdata[28:21]),
      .x_start        (req_tdata[44:29]),
      .x_end          (req_tdata[60:45]),
      .y_start        (req_tdata[76:61]),
      .y_end          (req_tdata[92:77]),
      .tex_coord      (req_tdata[124:93]),
      .tex_step       (req_tdata[156:125]),
      .texture_offset (req_tdata[188:157]),
      .cmd            (cmd),
      .stat           (stat),
      .status         (status),
      .read_value     (read_value)
   );

   assign rsp_tdata = {6'd0, read_value, status};

endmodule
